### design/rtefs_pkg.sv
// rtefs_pkg: shared types and constants of the route event flap suppressor
// used by the slot store, the register block and the top level
`timescale 1ns / 1ps

package rtefs_pkg;

  // request codes of an input transfer
  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_DEL  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_LOAD = 2'd3;

  // action codes
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_DEL = 1'b1;

  // configuration registers
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_FLAP   = 1'b0;
  localparam logic REG_SETTLE = 1'b1;
  localparam logic [15:0] FLAP_RESET   = 16'd10000;
  localparam logic [15:0] SETTLE_RESET = 16'd100;

  // most fire results one tick may produce
  localparam logic [3:0] MAX_FIRES = 4'd8;

  typedef struct packed {
    logic [31:0] addr;
    logic        valid;
    logic        immediate;
    logic        pending;
    logic        action;
    logic        running;
    logic [15:0] ticks;
  } slot_word_t;

  typedef struct packed {
    logic [15:0] flap;
    logic [15:0] settle;
  } cfg_t;

endpackage

### design/rtefs_in_if.sv
// rtefs_in_if: valid/ready channel carrying request transfers
// standalone, no package dependency
`timescale 1ns / 1ps

interface rtefs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] address;
  logic [2:0]  slot_index;
  logic        immediate_mode;
  logic        slot_enable;

  modport source (
    output valid, req_type, address, slot_index, immediate_mode, slot_enable,
    input  ready
  );
  modport sink (
    input  valid, req_type, address, slot_index, immediate_mode, slot_enable,
    output ready
  );
endinterface

### design/rtefs_out_if.sv
// rtefs_out_if: valid/ready channel carrying fire result transfers
// standalone, no package dependency
`timescale 1ns / 1ps

interface rtefs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  fired_slot;
  logic        fired_action;
  logic [31:0] fired_address;
  logic        last_of_run;

  modport source (
    output valid, fired_slot, fired_action, fired_address, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, fired_slot, fired_action, fired_address, last_of_run,
    output ready
  );
endinterface

### design/rtefs_slot_ram.sv
// rtefs_slot_ram: per-slot state memory, one write and one registered read port
// entries never written read as zero; depends on rtefs_pkg
`timescale 1ns / 1ps

module rtefs_slot_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output rtefs_pkg::slot_word_t rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  rtefs_pkg::slot_word_t wr_data
);

  rtefs_pkg::slot_word_t mem [DEPTH];
  logic [DEPTH-1:0]      written_r;
  rtefs_pkg::slot_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // written flags stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr_en) begin
      written_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= written_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/rtefs_cfg_regs.sv
// rtefs_cfg_regs: apb-style register block for the two delay registers
// depends on rtefs_pkg
`timescale 1ns / 1ps

module rtefs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rtefs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output rtefs_pkg::cfg_t                  cfg
);

  logic [15:0] flap_r;
  logic [15:0] settle_r;
  logic        wr_go;

  assign pready = 1'b1;
  assign wr_go  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flap_r   <= rtefs_pkg::FLAP_RESET;
      settle_r <= rtefs_pkg::SETTLE_RESET;
    end else if (wr_go) begin
      if (paddr[2] == rtefs_pkg::REG_FLAP) begin
        flap_r <= pwdata[15:0];
      end else begin
        settle_r <= pwdata[15:0];
      end
    end
  end

  assign prdata     = (paddr[2] == rtefs_pkg::REG_FLAP) ? {16'd0, flap_r} : {16'd0, settle_r};
  assign cfg.flap   = flap_r;
  assign cfg.settle = settle_r;

endmodule

### design/route_event_flap_suppressor_unit.sv
// route_event_flap_suppressor_unit: top level, scan sequencer and result staging
// depends on rtefs_pkg, rtefs_in_if, rtefs_out_if, rtefs_slot_ram, rtefs_cfg_regs
`timescale 1ns / 1ps

// channel   | dir | handshake            | contents
// ----------+-----+----------------------+-----------------------------------------
// in_ch     | in  | valid/ready          | req_type, address, slot_index, mode, enable
// out_ch    | out | valid/ready          | fired_slot, fired_action, fired_address, last
// cfg_*     | in  | apb setup + access   | flap_delay_ticks (0x0), settle_delay_ticks (0x4)
//
// a load transfer is written to the slot memory as it is accepted, and the block stays idle;
// a route event or tick reads every slot in turn through the single read port of the slot
// memory, processes the last slot, sees the scan drained and then passes the flush state
// reset (rst_n low, synchronous) clears control and the slot memory's written flags
// a stalled result output freezes the scan in place when a new result finds the hold full;
// the next input is taken once the final result of the run sits in the output register

module route_event_flap_suppressor_unit #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rtefs_in_if.sink                         in_ch,
  rtefs_out_if.source                      out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [rtefs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  rtefs_pkg::cfg_t cfg;

  rtefs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // sequencer and item registers
  logic [1:0]  state_r, state_nxt;
  logic [1:0]  type_r;
  logic [31:0] addr_r;
  logic        matched_r;
  logic [3:0]  fires_r;

  // read issue and process stage
  logic [SW-1:0] iss_slot_r;
  logic          iss_done_r;
  logic          p_valid_r;
  logic [SW-1:0] p_slot_r;

  // result staging: hold keeps the newest result until we know whether it is the last
  logic          hold_valid_r;
  logic [2:0]    hold_slot_r;
  logic          hold_act_r;
  logic [31:0]   hold_addr_r;
  logic          out_valid_r;
  logic [2:0]    out_slot_r;
  logic          out_act_r;
  logic [31:0]   out_addr_r;
  logic          out_last_r;

  // memory ports
  logic                  rd_en;
  rtefs_pkg::slot_word_t rd_data;
  logic                  wr_en;
  logic [SW-1:0]         wr_addr;
  rtefs_pkg::slot_word_t wr_data;

  // combinational
  logic                  in_go;
  logic                  is_load;
  logic                  load_ok;
  logic                  out_free;
  rtefs_pkg::slot_word_t wb;
  logic                  emit;
  logic                  emit_act;
  logic                  hit;
  logic                  stall;
  logic                  push_mid;
  logic                  push_last;
  logic                  scan_end;

  rtefs_slot_ram #(
    .DEPTH (NUM_SLOTS),
    .AW    (SW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (iss_slot_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_go       = in_ch.valid && in_ch.ready;
  assign is_load     = (in_ch.req_type == rtefs_pkg::REQ_LOAD);
  // loads beyond the table are dropped
  assign load_ok     = in_go && is_load && ({29'd0, in_ch.slot_index} < 32'(NUM_SLOTS));
  assign out_free    = !out_valid_r || out_ch.ready;

  // read-modify-write of the slot under the process stage
  always_comb begin
    wb       = rd_data;
    emit     = 1'b0;
    emit_act = rd_data.action;
    hit      = 1'b0;
    if (p_valid_r) begin
      if (type_r == rtefs_pkg::REQ_TICK) begin
        if (rd_data.running) begin
          if (rd_data.ticks > 16'd1) begin
            wb.ticks = rd_data.ticks - 16'd1;
          end else if (rd_data.pending && (fires_r >= rtefs_pkg::MAX_FIRES)) begin
            // over the per-tick cap: fire on a later tick
            wb.ticks = 16'd1;
          end else begin
            emit       = rd_data.pending;
            wb.pending = 1'b0;
            wb.action  = rtefs_pkg::ACT_ADD;
            wb.running = 1'b0;
            wb.ticks   = 16'd0;
          end
        end
      end else if (!matched_r && rd_data.valid && (rd_data.addr == addr_r)) begin
        // lowest matching slot owns the route event
        hit = 1'b1;
        if (rd_data.pending) begin
          if (rd_data.action != type_r[0]) begin
            // opposite action cancels
            wb.pending = 1'b0;
            wb.action  = rtefs_pkg::ACT_ADD;
            wb.running = 1'b0;
            wb.ticks   = 16'd0;
          end
        end else if (rd_data.immediate) begin
          wb.pending = 1'b1;
          wb.action  = type_r[0];
          wb.running = 1'b1;
          wb.ticks   = cfg.settle;
        end else if (type_r[0] == rtefs_pkg::ACT_ADD) begin
          // delayed add fires at once
          emit       = 1'b1;
          emit_act   = rtefs_pkg::ACT_ADD;
          wb.pending = 1'b0;
          wb.action  = rtefs_pkg::ACT_ADD;
          wb.running = 1'b0;
          wb.ticks   = 16'd0;
        end else begin
          wb.pending = 1'b1;
          wb.action  = rtefs_pkg::ACT_DEL;
          if (!rd_data.running) begin
            wb.running = 1'b1;
            wb.ticks   = cfg.flap;
          end
        end
      end
    end
  end

  // a second result needs the output register to take the held one
  assign stall     = p_valid_r && emit && hold_valid_r && !out_free;
  assign push_mid  = p_valid_r && emit && hold_valid_r && out_free;
  assign scan_end  = (state_r == ST_SCAN) && iss_done_r && !p_valid_r;
  assign push_last = (state_r == ST_FLUSH) && hold_valid_r && out_free;
  assign rd_en     = (state_r == ST_SCAN) && !iss_done_r && !stall;

  always_comb begin
    if (state_r == ST_IDLE) begin
      wr_en           = load_ok;
      wr_addr         = SW'(in_ch.slot_index);
      wr_data.addr      = in_ch.address;
      wr_data.valid     = in_ch.slot_enable;
      wr_data.immediate = in_ch.immediate_mode;
      wr_data.pending   = 1'b0;
      wr_data.action    = rtefs_pkg::ACT_ADD;
      wr_data.running   = 1'b0;
      wr_data.ticks     = 16'd0;
    end else begin
      wr_en   = p_valid_r && !stall;
      wr_addr = p_slot_r;
      wr_data = wb;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_go && !is_load) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      iss_done_r   <= 1'b1;
      p_valid_r    <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_go && !is_load) begin
        iss_done_r <= 1'b0;
      end else if (rd_en && (iss_slot_r == LAST_SLOT)) begin
        iss_done_r <= 1'b1;
      end
      if (!stall) begin
        p_valid_r <= rd_en;
      end
      if (p_valid_r && emit && !stall) begin
        hold_valid_r <= 1'b1;
      end else if (push_last) begin
        hold_valid_r <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and datapath registers
  always_ff @(posedge clk) begin
    if (in_go && !is_load) begin
      type_r     <= in_ch.req_type;
      addr_r     <= in_ch.address;
      matched_r  <= 1'b0;
      fires_r    <= 4'd0;
      iss_slot_r <= '0;
    end else begin
      if (rd_en && (iss_slot_r != LAST_SLOT)) begin
        iss_slot_r <= iss_slot_r + SW'(1);
      end
      if (!stall) begin
        if (hit) begin
          matched_r <= 1'b1;
        end
        if (p_valid_r && emit) begin
          fires_r <= fires_r + 4'd1;
        end
      end
    end
    if (!stall) begin
      p_slot_r <= iss_slot_r;
    end
    if (p_valid_r && emit && !stall) begin
      hold_slot_r <= 3'(p_slot_r);
      hold_act_r  <= emit_act;
      hold_addr_r <= rd_data.addr;
    end
    if (push_mid || push_last) begin
      out_slot_r <= hold_slot_r;
      out_act_r  <= hold_act_r;
      out_addr_r <= hold_addr_r;
      out_last_r <= push_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fired_slot    = out_slot_r;
  assign out_ch.fired_action  = out_act_r;
  assign out_ch.fired_address = out_addr_r;
  assign out_ch.last_of_run   = out_last_r;

endmodule

### tb/sv/tb_route_event_flap_suppressor_unit.sv
// tb_route_event_flap_suppressor_unit: self-checking bench for the route event flap suppressor
// predicts every fire transfer from its own copy of the slot table and delay registers
// depends on rtefs_pkg, rtefs_in_if, rtefs_out_if and route_event_flap_suppressor_unit
`timescale 1ns / 1ps

module tb_route_event_flap_suppressor_unit;
  import rtefs_pkg::*;

  localparam int NUM_SLOTS = 8;
  // scan of all slots plus result staging, with margin
  localparam int SCAN_CYCLES = 2 * NUM_SLOTS + 4;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [2:0]  slot_index;
    logic        imm;
    logic        en;
  } route_req_t;

  typedef struct packed {
    logic [2:0]  slot;
    logic        action;
    logic [31:0] addr;
    logic        last;
  } fire_t;

  // slot table predictor plus the queue of fire transfers still owed by the block
  class flap_fire_scoreboard;
    logic [31:0] watch_addr [NUM_SLOTS];
    bit          slot_on    [NUM_SLOTS];
    bit          slot_imm   [NUM_SLOTS];
    bit          pend       [NUM_SLOTS];
    logic        pend_act   [NUM_SLOTS];
    bit          running    [NUM_SLOTS];
    logic [15:0] ticks_left [NUM_SLOTS];
    logic [15:0] flap_ticks;
    logic [15:0] settle_ticks;
    fire_t       fires_due[$];
    fire_t       batch[$];
    int          errors;

    function new();
      int s;
      for (s = 0; s < NUM_SLOTS; s++) begin
        watch_addr[s] = '0;
        slot_on[s]    = 1'b0;
        slot_imm[s]   = 1'b0;
        clear_slot(s);
      end
      flap_ticks   = FLAP_RESET;
      settle_ticks = SETTLE_RESET;
      errors       = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] value);
      if (idx == REG_FLAP) begin
        flap_ticks = value;
      end else begin
        settle_ticks = value;
      end
    endfunction

    function void clear_slot(int s);
      pend[s]       = 1'b0;
      pend_act[s]   = ACT_ADD;
      running[s]    = 1'b0;
      ticks_left[s] = '0;
    endfunction

    function void fire(int s, logic act);
      batch.push_back(fire_t'{slot: 3'(s), action: act, addr: watch_addr[s], last: 1'b0});
    endfunction

    // lowest enabled slot watching the address handles the event
    function void route_event(logic act, logic [31:0] addr);
      int s;
      int hit;
      hit = -1;
      for (s = NUM_SLOTS - 1; s >= 0; s--) begin
        if (slot_on[s] && watch_addr[s] == addr) hit = s;
      end
      if (hit < 0) return;
      if (pend[hit]) begin
        // opposite action cancels, same action is dropped
        if (pend_act[hit] != act) clear_slot(hit);
        return;
      end
      pend[hit]     = 1'b1;
      pend_act[hit] = act;
      if (slot_imm[hit]) begin
        running[hit]    = 1'b1;
        ticks_left[hit] = settle_ticks;
      end else if (act == ACT_ADD) begin
        fire(hit, ACT_ADD);
        clear_slot(hit);
      end else if (!running[hit]) begin
        running[hit]    = 1'b1;
        ticks_left[hit] = flap_ticks;
      end
    endfunction

    // a running timer at 0 or 1 expires; overflow beyond the result cap waits a tick
    function void tick_all();
      int s;
      int n;
      n = 0;
      for (s = 0; s < NUM_SLOTS; s++) begin
        if (!running[s]) continue;
        if (ticks_left[s] > 16'd1) begin
          ticks_left[s] = ticks_left[s] - 16'd1;
          continue;
        end
        if (pend[s]) begin
          if (n >= int'(MAX_FIRES)) begin
            ticks_left[s] = 16'd1;
            continue;
          end
          fire(s, pend_act[s]);
          n++;
        end
        clear_slot(s);
      end
    endfunction

    function void note_request(route_req_t r);
      int s;
      batch.delete();
      case (r.kind)
        REQ_ADD:  route_event(ACT_ADD, r.addr);
        REQ_DEL:  route_event(ACT_DEL, r.addr);
        REQ_TICK: tick_all();
        REQ_LOAD: begin
          s = int'(r.slot_index);
          if (s < NUM_SLOTS) begin
            watch_addr[s] = r.addr;
            slot_imm[s]   = r.imm;
            slot_on[s]    = r.en;
            clear_slot(s);
          end
        end
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) fires_due.push_back(batch[i]);
    endfunction

    function void check_fire(fire_t got);
      fire_t want;
      if (fires_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected fire, actual slot %0d action %0d addr %h last %0d",
                 $time, got.slot, got.action, got.addr, got.last);
        return;
      end
      want = fires_due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: fire mismatch, expected %0d/%0d/%h/%0d actual %0d/%0d/%h/%0d",
                 $time, want.slot, want.action, want.addr, want.last,
                 got.slot, got.action, got.addr, got.last);
      end
    endfunction

    function void check_drained();
      if (fires_due.size() != 0) begin
        errors += fires_due.size();
        $display("%0t: %0d expected fires never arrived", $time, fires_due.size());
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rtefs_in_if  in_ch ();
  rtefs_out_if out_ch ();

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  flap_fire_scoreboard sb;

  // idle percentages of the two sides, and a long receiver hold-off in cycles
  int send_idle_pct = 8;
  int recv_idle_pct = 64;
  int hold_left     = 0;
  int reqs_sent     = 0;

  // addresses the random part draws from, so events hit watched slots
  logic [31:0] addr_pool [8];

  route_event_flap_suppressor_unit #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // every accepted request transfer feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_request(route_req_t'{kind: in_ch.req_type, addr: in_ch.address,
                                   slot_index: in_ch.slot_index,
                                   imm: in_ch.immediate_mode, en: in_ch.slot_enable});
    end
  end

  // every accepted fire transfer is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_fire(fire_t'{slot: out_ch.fired_slot, action: out_ch.fired_action,
                            addr: out_ch.fired_address, last: out_ch.last_of_run});
    end
  end

  // receiver: random stalls, or a long hold-off while hold_left runs down
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // run limit, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // one request transfer; valid stays high afterwards unless the next call gaps
  task automatic send_req(input logic [1:0] kind, input logic [31:0] addr,
                          input logic [2:0] idx, input logic imm, input logic en);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= kind;
    in_ch.address        <= addr;
    in_ch.slot_index     <= idx;
    in_ch.immediate_mode <= imm;
    in_ch.slot_enable    <= en;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    reqs_sent++;
  endtask

  // load-only fields carry random junk on events and ticks
  task automatic send_event(input logic [1:0] kind, input logic [31:0] addr);
    send_req(kind, addr, 3'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic send_tick();
    send_event(REQ_TICK, $urandom());
  endtask

  task automatic send_load(input logic [2:0] idx, input logic [31:0] addr,
                           input logic imm, input logic en);
    send_req(REQ_LOAD, addr, idx, imm, en);
  endtask

  // drop valid, wait for all owed fires, then let a scan with no result finish
  task automatic drain();
    int n;
    in_ch.valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && sb.fires_due.size() != 0; n++) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  // apb setup then access; the transfer completes at the edge with pready high
  task automatic apb_xfer(input logic idx, input logic wr, input logic [15:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'h0000, wdata};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_reg(input logic idx, input logic [15:0] want);
    logic [31:0] got;
    apb_xfer(idx, 1'b0, 16'h0000, got);
    if (got[15:0] !== want) begin
      sb.errors++;
      $display("%0t: register %0d readback expected %0d actual %0d",
               $time, idx, want, got[15:0]);
    end
  endtask

  task automatic set_delays(input logic [15:0] flap, input logic [15:0] settle);
    logic [31:0] unused;
    apb_xfer(REG_FLAP, 1'b1, flap, unused);
    sb.set_reg(REG_FLAP, flap);
    apb_xfer(REG_SETTLE, 1'b1, settle, unused);
    sb.set_reg(REG_SETTLE, settle);
    check_reg(REG_FLAP, flap);
    check_reg(REG_SETTLE, settle);
  endtask

  function automatic logic [31:0] pool_addr();
    if ($urandom_range(9) == 0) return $urandom();
    return addr_pool[$urandom_range(7)];
  endfunction

  // fill every slot, hit each with one event, then send three ticks
  task automatic slot_burst(input bit all_imm);
    int s;
    for (s = 0; s < NUM_SLOTS; s++) begin
      send_load(3'(s), addr_pool[s], all_imm ? 1'b1 : 1'($urandom), 1'b1);
    end
    for (s = 0; s < NUM_SLOTS; s++) begin
      send_event($urandom_range(1) ? REQ_DEL : REQ_ADD, addr_pool[s]);
    end
    repeat (3) send_tick();
  endtask

  initial begin
    int phase;
    int rnd;
    bit pressure_done;

    sb = new();
    in_ch.valid          <= 1'b0;
    in_ch.req_type       <= REQ_TICK;
    in_ch.address        <= '0;
    in_ch.slot_index     <= '0;
    in_ch.immediate_mode <= 1'b0;
    in_ch.slot_enable    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers come out of reset with their documented delays
    check_reg(REG_FLAP, FLAP_RESET);
    check_reg(REG_SETTLE, SETTLE_RESET);

    // reset delays: delayed add fires at once, immediate add is cancelled by a delete
    send_load(3'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_event(REQ_ADD, 32'hFFFF_FFFF);
    send_load(3'd7, 32'h0000_0000, 1'b1, 1'b1);
    send_event(REQ_ADD, 32'h0000_0000);
    send_event(REQ_DEL, 32'h0000_0000);
    // no slot watches this one
    send_event(REQ_ADD, 32'h0000_0009);
    send_tick();
    drain();

    set_delays(16'd2, 16'd1);
    // same address in two slots, the lower one wins
    send_load(3'd1, 32'h1234_5678, 1'b1, 1'b1);
    send_load(3'd2, 32'h1234_5678, 1'b0, 1'b1);
    send_event(REQ_DEL, 32'h1234_5678);
    // same action again is dropped
    send_event(REQ_DEL, 32'h1234_5678);
    send_tick();
    // disabled slot steps aside, the delayed slot takes over
    send_load(3'd1, 32'h1234_5678, 1'b1, 1'b0);
    send_event(REQ_DEL, 32'h1234_5678);
    send_event(REQ_ADD, 32'h1234_5678);
    send_event(REQ_DEL, 32'h1234_5678);
    send_tick();
    send_tick();
    // a reload wipes the pending action, so its timer never fires
    send_load(3'd3, 32'hA5A5_A5A5, 1'b1, 1'b1);
    send_event(REQ_ADD, 32'hA5A5_A5A5);
    send_load(3'd3, 32'hA5A5_A5A5, 1'b1, 1'b1);
    send_tick();
    drain();

    // random part: new delays every 40 transfers, idling pattern by progress
    phase         = -1;
    pressure_done = 1'b0;
    reqs_sent     = 0;
    while (reqs_sent < 150) begin
      if (reqs_sent / 40 != phase) begin
        phase = reqs_sent / 40;
        drain();
        case (phase)
          0:       set_delays(16'd3, 16'd2);
          1:       set_delays(16'hFFFF, 16'd1);
          2:       set_delays(16'd2, 16'd0);
          3:       set_delays(16'd1, 16'hFFFF);
          default: set_delays(16'($urandom_range(6)), 16'($urandom_range(6)));
        endcase
        for (rnd = 0; rnd < 6; rnd++) addr_pool[rnd] = $urandom();
        addr_pool[6] = 32'h0000_0000;
        addr_pool[7] = 32'hFFFF_FFFF;
      end

      if (reqs_sent < 50) begin
        send_idle_pct = 8;
        recv_idle_pct = 64;
      end else if (reqs_sent < 100) begin
        send_idle_pct = 64;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // receiver holds off while a full burst of fires piles up behind it
      if (!pressure_done && reqs_sent >= 100) begin
        pressure_done = 1'b1;
        hold_left     = 300;
        slot_burst(1'b1);
        continue;
      end

      rnd = $urandom_range(99);
      if (rnd < 15) begin
        send_load(3'($urandom), pool_addr(), 1'($urandom), $urandom_range(9) != 0);
      end else if (rnd < 55) begin
        send_event($urandom_range(1) ? REQ_DEL : REQ_ADD, pool_addr());
      end else if (rnd < 85) begin
        send_tick();
      end else if (rnd < 93) begin
        send_event($urandom_range(1) ? REQ_DEL : REQ_ADD, $urandom());
      end else begin
        slot_burst(1'b0);
      end
    end

    drain();
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
design/rtefs_pkg.sv
design/rtefs_in_if.sv
design/rtefs_out_if.sv
design/rtefs_slot_ram.sv
design/rtefs_cfg_regs.sv
design/route_event_flap_suppressor_unit.sv
tb/sv/tb_route_event_flap_suppressor_unit.sv
